// ----- rtl/ptrk_pkg.sv -----
// Package: types, constants and helper functions of the pointer tracker.
package ptrk_pkg;

  localparam int S_DATA_W = 120;
  localparam int S_USER_W = 4;
  localparam int M_DATA_W = 80;
  localparam int CFG_W    = 16;

  localparam logic [3:0] OP_MDOWN   = 4'd0;
  localparam logic [3:0] OP_MUP     = 4'd1;
  localparam logic [3:0] OP_MMOVE   = 4'd2;
  localparam logic [3:0] OP_WHEEL   = 4'd3;
  localparam logic [3:0] OP_TSTART  = 4'd4;
  localparam logic [3:0] OP_TMOVE   = 4'd5;
  localparam logic [3:0] OP_TEND    = 4'd6;
  localparam logic [3:0] OP_TCANCEL = 4'd7;
  localparam logic [3:0] OP_POLL    = 4'd8;

  localparam logic [CFG_W-1:0] TAP_RADIUS_RESET = 16'd25;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [2:0]         button;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [23:0] wheel_x;
    logic signed [23:0] wheel_y;
    logic               touch_upd;
  } event_t;

  typedef struct packed {
    logic [7:0]         buttons;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic               wheel_up;
    logic               wheel_down;
    logic               hwheel_up;
    logic               hwheel_down;
  } result_t;

  // saturating add of a 24-bit signed delta to a 32-bit signed sum
  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [23:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {{9{b[23]}}, b};
    if (s[32] != s[31]) begin
      sat_add32 = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_add32 = s[31:0];
    end
  endfunction

endpackage

// ----- rtl/ptrk_in_stage.sv -----
// Input register: accepts one event transfer and unpacks the stream fields.
module ptrk_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ptrk_pkg::S_DATA_W-1:0] s_tdata,
  input  logic [ptrk_pkg::S_USER_W-1:0] s_tuser,
  input  logic                          adv,
  output logic                          valid,
  output ptrk_pkg::event_t              ev
);
  import ptrk_pkg::*;

  assign s_tready = !rst && (!valid || adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      ev.opcode    <= s_tuser;
      ev.button    <= s_tdata[2:0];
      ev.pos_x     <= s_tdata[18:3];
      ev.pos_y     <= s_tdata[34:19];
      ev.move_x    <= s_tdata[50:35];
      ev.move_y    <= s_tdata[66:51];
      ev.wheel_x   <= s_tdata[90:67];
      ev.wheel_y   <= s_tdata[114:91];
      ev.touch_upd <= s_tdata[115];
    end
  end

endmodule

// ----- rtl/ptrk_engine.sv -----
// Pointer state registers, tap radius register and the per-event update logic.
module ptrk_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ptrk_pkg::CFG_W-1:0] cfg_data,
  input  logic                       fire,
  input  ptrk_pkg::event_t           ev,
  output ptrk_pkg::result_t          res
);
  import ptrk_pkg::*;

  logic [CFG_W-1:0]   tap_radius;
  logic signed [15:0] pointer_x, pointer_y;
  logic signed [31:0] pending_dx, pending_dy, latched_dx, latched_dy;
  logic signed [31:0] scroll_acc_x, scroll_acc_y;
  logic signed [31:0] latched_scroll_x, latched_scroll_y;
  logic [7:0]         button_mask;
  logic signed [15:0] last_touch_x, last_touch_y;
  logic signed [16:0] touchdown_sum;
  logic               tapped_once, tapped_twice;

  logic signed [15:0] pointer_x_next, pointer_y_next;
  logic signed [31:0] pending_dx_next, pending_dy_next, latched_dx_next, latched_dy_next;
  logic signed [31:0] scroll_acc_x_next, scroll_acc_y_next;
  logic signed [31:0] latched_scroll_x_next, latched_scroll_y_next;
  logic [7:0]         button_mask_next;
  logic signed [15:0] last_touch_x_next, last_touch_y_next;
  logic signed [16:0] touchdown_sum_next;
  logic               tapped_once_next, tapped_twice_next;

  logic [7:0]         mask;
  logic signed [16:0] pos_sum;
  logic signed [17:0] tap_diff;
  logic [17:0]        tap_abs;
  logic               near;
  logic signed [16:0] tdx, tdy, tdx_adj, tdy_adj;
  logic signed [15:0] half_dx, half_dy;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_radius <= TAP_RADIUS_RESET;
    end else if (cfg_valid) begin
      tap_radius <= cfg_data;
    end
  end

  always_comb begin
    mask     = 8'd1 << ev.button;
    pos_sum  = {ev.pos_x[15], ev.pos_x} + {ev.pos_y[15], ev.pos_y};
    tap_diff = {touchdown_sum[16], touchdown_sum} - {pos_sum[16], pos_sum};
    tap_abs  = tap_diff[17] ? 18'(-tap_diff) : 18'(tap_diff);
    near     = tap_abs < {2'b00, tap_radius};
    // halve toward zero
    tdx      = {ev.pos_x[15], ev.pos_x} - {last_touch_x[15], last_touch_x};
    tdy      = {ev.pos_y[15], ev.pos_y} - {last_touch_y[15], last_touch_y};
    tdx_adj  = tdx + {16'd0, tdx[16]};
    tdy_adj  = tdy + {16'd0, tdy[16]};
    half_dx  = tdx_adj[16:1];
    half_dy  = tdy_adj[16:1];
  end

  always_comb begin
    pointer_x_next        = pointer_x;
    pointer_y_next        = pointer_y;
    pending_dx_next       = pending_dx;
    pending_dy_next       = pending_dy;
    latched_dx_next       = latched_dx;
    latched_dy_next       = latched_dy;
    scroll_acc_x_next     = scroll_acc_x;
    scroll_acc_y_next     = scroll_acc_y;
    latched_scroll_x_next = latched_scroll_x;
    latched_scroll_y_next = latched_scroll_y;
    button_mask_next      = button_mask;
    last_touch_x_next     = last_touch_x;
    last_touch_y_next     = last_touch_y;
    touchdown_sum_next    = touchdown_sum;
    tapped_once_next      = tapped_once;
    tapped_twice_next     = tapped_twice;
    case (ev.opcode)
      OP_MDOWN, OP_MUP, OP_MMOVE: begin
        pointer_x_next  = ev.pos_x;
        pointer_y_next  = ev.pos_y;
        pending_dx_next = sat_add32(pending_dx, {{8{ev.move_x[15]}}, ev.move_x});
        pending_dy_next = sat_add32(pending_dy, {{8{ev.move_y[15]}}, ev.move_y});
        if (ev.opcode == OP_MDOWN) begin
          button_mask_next = button_mask | mask;
        end else if (ev.opcode == OP_MUP) begin
          button_mask_next = button_mask & ~mask;
        end
      end
      OP_WHEEL: begin
        scroll_acc_x_next = sat_add32(scroll_acc_x, ev.wheel_x);
        scroll_acc_y_next = sat_add32(scroll_acc_y, ev.wheel_y);
      end
      OP_TSTART: begin
        if (ev.touch_upd) begin
          last_touch_x_next = ev.pos_x;
          last_touch_y_next = ev.pos_y;
          if (tapped_once && !tapped_twice && near) begin
            tapped_twice_next = 1'b1;
            button_mask_next  = button_mask | 8'd1;
          end else begin
            tapped_once_next   = 1'b1;
            tapped_twice_next  = 1'b0;
            touchdown_sum_next = pos_sum;
          end
        end
      end
      OP_TMOVE: begin
        if (ev.touch_upd) begin
          last_touch_x_next = ev.pos_x;
          last_touch_y_next = ev.pos_y;
          pointer_x_next    = ev.pos_x;
          pointer_y_next    = ev.pos_y;
          pending_dx_next   = sat_add32(pending_dx, {{8{half_dx[15]}}, half_dx});
          pending_dy_next   = sat_add32(pending_dy, {{8{half_dy[15]}}, half_dy});
        end
      end
      OP_TEND, OP_TCANCEL: begin
        if (ev.touch_upd) begin
          if (tapped_once && tapped_twice) begin
            button_mask_next  = button_mask & 8'hFE;
            tapped_once_next  = 1'b0;
            tapped_twice_next = 1'b0;
          end else if (!near) begin
            tapped_once_next  = 1'b0;
            tapped_twice_next = 1'b0;
          end
        end
      end
      OP_POLL: begin
        latched_dx_next       = pending_dx;
        latched_dy_next       = pending_dy;
        pending_dx_next       = 32'sd0;
        pending_dy_next       = 32'sd0;
        latched_scroll_x_next = scroll_acc_x;
        latched_scroll_y_next = scroll_acc_y;
        scroll_acc_x_next     = 32'sd0;
        scroll_acc_y_next     = 32'sd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_x        <= '0;
      pointer_y        <= '0;
      pending_dx       <= '0;
      pending_dy       <= '0;
      latched_dx       <= '0;
      latched_dy       <= '0;
      scroll_acc_x     <= '0;
      scroll_acc_y     <= '0;
      latched_scroll_x <= '0;
      latched_scroll_y <= '0;
      button_mask      <= '0;
      last_touch_x     <= '0;
      last_touch_y     <= '0;
      touchdown_sum    <= '0;
      tapped_once      <= 1'b0;
      tapped_twice     <= 1'b0;
    end else if (fire) begin
      pointer_x        <= pointer_x_next;
      pointer_y        <= pointer_y_next;
      pending_dx       <= pending_dx_next;
      pending_dy       <= pending_dy_next;
      latched_dx       <= latched_dx_next;
      latched_dy       <= latched_dy_next;
      scroll_acc_x     <= scroll_acc_x_next;
      scroll_acc_y     <= scroll_acc_y_next;
      latched_scroll_x <= latched_scroll_x_next;
      latched_scroll_y <= latched_scroll_y_next;
      button_mask      <= button_mask_next;
      last_touch_x     <= last_touch_x_next;
      last_touch_y     <= last_touch_y_next;
      touchdown_sum    <= touchdown_sum_next;
      tapped_once      <= tapped_once_next;
      tapped_twice     <= tapped_twice_next;
    end
  end

  always_comb begin
    res.buttons     = button_mask_next;
    res.screen_x    = pointer_x_next;
    res.screen_y    = pointer_y_next;
    res.delta_x     = latched_dx_next[15:0];
    res.delta_y     = latched_dy_next[15:0];
    res.wheel_up    = latched_scroll_y_next[31];
    res.wheel_down  = !latched_scroll_y_next[31] && (latched_scroll_y_next != 32'sd0);
    res.hwheel_up   = latched_scroll_x_next[31];
    res.hwheel_down = !latched_scroll_x_next[31] && (latched_scroll_x_next != 32'sd0);
  end

endmodule

// ----- rtl/ptrk_out_stage.sv -----
// Result register: holds one packed result until the downstream transfer.
module ptrk_out_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  ptrk_pkg::result_t             res,
  output logic                          adv,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ptrk_pkg::M_DATA_W-1:0] m_tdata
);
  import ptrk_pkg::*;

  assign adv = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      m_tdata <= {4'd0, res.hwheel_down, res.hwheel_up, res.wheel_down, res.wheel_up,
                  res.delta_y, res.delta_x, res.screen_y, res.screen_x, res.buttons};
    end
  end

endmodule

// ----- rtl/touch_mouse_pointer_tracker_core.sv -----
// Top level of the touch and mouse pointer tracker.
//
//  channel  dir  handshake             payload
//  cfg      in   cfg_valid/cfg_ready   cfg_data: tap_radius
//  s        in   s_tvalid/s_tready     s_tuser: opcode; s_tdata: event fields
//  m        out  m_tvalid/m_tready     m_tdata: result fields
//
// One event per cycle unless the result stalls; m_tvalid rises once an
// event passes the input register, then the result register. The update
// logic runs on the registered event as it moves into the result register.
// rst clears all state and sets tap_radius to 25; no transfers during rst.
// A stalled result holds both stages; s_tready drops only when both are full.
module touch_mouse_pointer_tracker_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptrk_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // button[2:0] pos_x[18:3] pos_y[34:19] move_x[50:35] move_y[66:51]
  // wheel_x[90:67] wheel_y[114:91] touch_upd[115], zero pad
  input  logic [ptrk_pkg::S_DATA_W-1:0] s_tdata,
  // opcode[3:0]
  input  logic [ptrk_pkg::S_USER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // buttons[7:0] screen_x[23:8] screen_y[39:24] delta_x[55:40] delta_y[71:56]
  // wheel_up[72] wheel_down[73] hwheel_up[74] hwheel_down[75], zero pad
  output logic [ptrk_pkg::M_DATA_W-1:0] m_tdata
);
  import ptrk_pkg::*;

  logic    adv;
  logic    ev_valid;
  event_t  ev;
  result_t res;

  ptrk_in_stage u_in (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .adv(adv), .valid(ev_valid), .ev(ev)
  );

  ptrk_engine u_engine (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fire(ev_valid && adv), .ev(ev), .res(res)
  );

  ptrk_out_stage u_out (
    .clk(clk), .rst(rst),
    .in_valid(ev_valid), .res(res), .adv(adv),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule

// ----- rtl/ptrk_checker.sv -----
// Port-level checker for the pointer tracker, bound to the top level.
module ptrk_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ptrk_pkg::M_DATA_W-1:0] m_tdata
);
  import ptrk_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  a_vwheel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[72] && m_tdata[73]))
    else $error("vertical scroll both ways");

  a_hwheel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[74] && m_tdata[75]))
    else $error("horizontal scroll both ways");

endmodule

bind touch_mouse_pointer_tracker_core ptrk_checker u_ptrk_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ----- verif/touch_mouse_pointer_tracker_core_test.sv -----
// Testbench of the pointer tracker core: directed table, random event traffic and saturation runs.
module touch_mouse_pointer_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ptrk_pkg::*;

  localparam logic [3:0] OP_SPARE_LO = 4'd9;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam int TOUCH_STEP_DIV = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    event_t  ev;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // tracker state as predicted
  logic [15:0]        tap_radius_now = TAP_RADIUS_RESET;
  logic signed [15:0] cur_x = '0, cur_y = '0;
  logic signed [31:0] pend_dx = '0, pend_dy = '0, held_dx = '0, held_dy = '0;
  logic signed [31:0] pend_sx = '0, pend_sy = '0, held_sx = '0, held_sy = '0;
  logic [7:0]         mask_now = '0;
  logic signed [15:0] touch_x = '0, touch_y = '0;
  logic signed [16:0] down_sum = '0;
  bit                 first_tap = 1'b0, second_tap = 1'b0;

  result_t   expected_views[$];
  plan_row_t plan[$];
  int        mismatches = 0;
  int        accepted_events = 0;
  int        quiet_cycles = 0;
  int        src_idle_pct = 0;
  int        sink_idle_pct = 0;

  touch_mouse_pointer_tracker_core uut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp_sum(input logic signed [31:0] acc,
                                                  input longint step);
    longint s;
    s = acc + step;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic bit is_near(input longint x, input longint y);
    longint d;
    d = down_sum - (x + y);
    if (d < 0) d = -d;
    return d < longint'(tap_radius_now);
  endfunction

  function automatic result_t track_pointer(input event_t ev);
    longint  px, py, hx, hy;
    result_t r;
    px = ev.pos_x;
    py = ev.pos_y;
    if (ev.opcode <= OP_MMOVE) begin
      cur_x = ev.pos_x;
      cur_y = ev.pos_y;
      pend_dx = clamp_sum(pend_dx, ev.move_x);
      pend_dy = clamp_sum(pend_dy, ev.move_y);
      if (ev.opcode == OP_MDOWN) mask_now = mask_now | (8'd1 << ev.button);
      else if (ev.opcode == OP_MUP) mask_now = mask_now & ~(8'd1 << ev.button);
    end else if (ev.opcode == OP_WHEEL) begin
      pend_sx = clamp_sum(pend_sx, ev.wheel_x);
      pend_sy = clamp_sum(pend_sy, ev.wheel_y);
    end else if (ev.opcode == OP_TSTART && ev.touch_upd) begin
      touch_x = ev.pos_x;
      touch_y = ev.pos_y;
      if (first_tap && !second_tap && is_near(px, py)) begin
        second_tap = 1'b1;
        mask_now[0] = 1'b1;
      end else begin
        first_tap = 1'b1;
        second_tap = 1'b0;
        down_sum = 17'(px + py);
      end
    end else if (ev.opcode == OP_TMOVE && ev.touch_upd) begin
      hx = (px - touch_x) / TOUCH_STEP_DIV;
      hy = (py - touch_y) / TOUCH_STEP_DIV;
      touch_x = ev.pos_x;
      touch_y = ev.pos_y;
      cur_x = ev.pos_x;
      cur_y = ev.pos_y;
      pend_dx = clamp_sum(pend_dx, hx);
      pend_dy = clamp_sum(pend_dy, hy);
    end else if ((ev.opcode == OP_TEND || ev.opcode == OP_TCANCEL) && ev.touch_upd) begin
      if (first_tap && second_tap) begin
        mask_now[0] = 1'b0;
        first_tap = 1'b0;
        second_tap = 1'b0;
      end else if (!is_near(px, py)) begin
        first_tap = 1'b0;
        second_tap = 1'b0;
      end
    end else if (ev.opcode == OP_POLL) begin
      held_dx = pend_dx;
      held_dy = pend_dy;
      held_sx = pend_sx;
      held_sy = pend_sy;
      pend_dx = '0;
      pend_dy = '0;
      pend_sx = '0;
      pend_sy = '0;
    end
    r.buttons = mask_now;
    r.screen_x = cur_x;
    r.screen_y = cur_y;
    r.delta_x = held_dx[15:0];
    r.delta_y = held_dy[15:0];
    r.wheel_up = held_sy < 0;
    r.wheel_down = held_sy > 0;
    r.hwheel_up = held_sx < 0;
    r.hwheel_down = held_sx > 0;
    return r;
  endfunction

  function automatic event_t pointer_event(input logic [3:0] op, input logic [2:0] btn,
                                           input int px, py, mx, my, wx, wy,
                                           input logic changed);
    event_t ev;
    ev.opcode = op;
    ev.button = btn;
    ev.pos_x = 16'(px);
    ev.pos_y = 16'(py);
    ev.move_x = 16'(mx);
    ev.move_y = 16'(my);
    ev.wheel_x = 24'(wx);
    ev.wheel_y = 24'(wy);
    ev.touch_upd = changed;
    return ev;
  endfunction

  function automatic event_t random_event();
    logic [127:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom};
    return noise[119:0];
  endfunction

  function automatic event_t touch_at(input logic [3:0] op, input logic signed [15:0] cx, cy,
                                      input int spread);
    event_t ev;
    int     off_x, off_y;
    ev = random_event();
    off_x = int'($urandom_range(2 * spread)) - spread;
    off_y = int'($urandom_range(2 * spread)) - spread;
    ev.opcode = op;
    ev.touch_upd = ($urandom_range(15) != 0);
    ev.pos_x = 16'(cx + off_x);
    ev.pos_y = 16'(cy + off_y);
    return ev;
  endfunction

  task automatic send_event(input event_t ev, input bit typed = 1'b0,
                            input result_t want = '0);
    result_t view;
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= ev.opcode;
    s_tdata <= S_DATA_W'({ev.touch_upd, ev.wheel_y, ev.wheel_x, ev.move_y, ev.move_x,
                          ev.pos_y, ev.pos_x, ev.button});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    view = track_pointer(ev);
    expected_views.push_back(typed ? want : view);
    accepted_events++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tap_radius(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tap_radius_now = value;
  endtask

  // one or more taps near one spot, each with up to three drags and a lift
  task automatic send_gesture();
    logic signed [15:0] cx, cy;
    int                 spread, taps, moves;
    cx = 16'($urandom);
    cy = 16'($urandom);
    spread = ($urandom_range(3) == 0) ? 400 : 24;
    taps = $urandom_range(1, 3);
    repeat (taps) begin
      send_event(touch_at(OP_TSTART, cx, cy, spread));
      moves = $urandom_range(3);
      repeat (moves) send_event(touch_at(OP_TMOVE, cx, cy, spread));
      send_event(touch_at($urandom_range(1) ? OP_TEND : OP_TCANCEL, cx, cy, spread));
    end
  endtask

  task automatic send_random(input int count);
    event_t ev;
    int     stop, pick;
    stop = accepted_events + count;
    while (accepted_events < stop) begin
      ev = random_event();
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_gesture();
      end else begin
        if (pick < 60) begin
          ev.opcode = 4'($urandom_range(OP_MMOVE));
          if ($urandom_range(3) != 0) begin
            ev.move_x = 16'(int'($urandom_range(512)) - 256);
            ev.move_y = 16'(int'($urandom_range(512)) - 256);
          end
        end else if (pick < 70) begin
          ev.opcode = OP_WHEEL;
        end else if (pick < 85) begin
          ev.opcode = OP_POLL;
        end else begin
          ev.opcode = 4'($urandom_range(OP_SPARE_HI));
        end
        send_event(ev);
      end
    end
  endtask

  // long one-sided run to drive the pending sums into saturation, then latch them
  task automatic flood(input logic [3:0] op, input int along_x, along_y, input int count);
    event_t ev;
    repeat (count) begin
      ev = random_event();
      ev.opcode = op;
      ev.move_x = 16'(along_x);
      ev.move_y = 16'(along_y);
      ev.wheel_x = 24'(along_x);
      ev.wheel_y = 24'(along_y);
      send_event(ev);
    end
    ev.opcode = OP_POLL;
    send_event(ev);
  endtask

  always @(posedge clk) begin : monitor
    result_t got, want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
    if (m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tdata[23:8], m_tdata[39:24], m_tdata[55:40], m_tdata[71:56],
             m_tdata[72], m_tdata[73], m_tdata[74], m_tdata[75]};
      if (expected_views.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %p", $time, got);
        mismatches++;
      end else begin
        want = expected_views.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
          mismatches++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : run
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct = 25;
    sink_idle_pct = 51;

    plan.push_back(plan_row_t'{pointer_event(OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               result_t'({8'h00, 64'h0, 4'b0000})});
    plan.push_back(plan_row_t'{pointer_event(OP_MMOVE, 0, 32767, -32768, 0, 0, 0, 0, 0), 1'b1,
                               result_t'({8'h00, 16'h7FFF, 16'h8000, 32'h0, 4'b0000})});
    plan.push_back(plan_row_t'{pointer_event(OP_MDOWN, 7, -32768, 32767, 32767, -32768,
                                             0, 0, 0), 1'b1,
                               result_t'({8'h80, 16'h8000, 16'h7FFF, 32'h0, 4'b0000})});
    plan.push_back(plan_row_t'{pointer_event(OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               result_t'({8'h80, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                                          4'b0000})});
    plan.push_back(plan_row_t'{pointer_event(OP_MUP, 7, 0, 0, -32768, 32767, 0, 0, 0), 1'b1,
                               result_t'({8'h00, 32'h0, 16'h7FFF, 16'h8000, 4'b0000})});
    plan.push_back(plan_row_t'{pointer_event(OP_WHEEL, 0, 0, 0, 0, 0, 8388607, -8388608, 0),
                               1'b1, result_t'({8'h00, 32'h0, 16'h7FFF, 16'h8000, 4'b0000})});
    plan.push_back(plan_row_t'{pointer_event(OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               result_t'({8'h00, 32'h0, 16'h8000, 16'h7FFF, 4'b1001})});
    plan.push_back(plan_row_t'{pointer_event(OP_SPARE_LO, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1,
                               result_t'({8'h00, 32'h0, 16'h8000, 16'h7FFF, 4'b1001})});
    plan.push_back(plan_row_t'{pointer_event(OP_SPARE_HI, 7, 1, 1, 1, 1, 1, 1, 1), 1'b1,
                               result_t'({8'h00, 32'h0, 16'h8000, 16'h7FFF, 4'b1001})});
    plan.push_back(plan_row_t'{pointer_event(OP_TSTART, 0, 100, 100, 0, 0, 0, 0, 0), 1'b1,
                               result_t'({8'h00, 32'h0, 16'h8000, 16'h7FFF, 4'b1001})});
    plan.push_back(plan_row_t'{pointer_event(OP_TSTART, 0, 100, 100, 0, 0, 0, 0, 1), 1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_TEND, 0, 105, 100, 0, 0, 0, 0, 1), 1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_TSTART, 0, 110, 108, 0, 0, 0, 0, 1), 1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_TMOVE, 0, 121, 91, 0, 0, 0, 0, 1), 1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_TMOVE, 0, 500, 500, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_TEND, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_TSTART, 0, 1000, 1000, 0, 0, 0, 0, 1),
                               1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_TCANCEL, 0, 2000, 0, 0, 0, 0, 0, 1), 1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_TCANCEL, 0, 5000, 5000, 0, 0, 0, 0, 1),
                               1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_TSTART, 0, 1000, 1000, 0, 0, 0, 0, 1),
                               1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_TSTART, 0, 1012, 1012, 0, 0, 0, 0, 1),
                               1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_TSTART, 0, 1000, 1000, 0, 0, 0, 0, 1),
                               1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_TEND, 0, 3000, 3000, 0, 0, 0, 0, 1), 1'b0, '0});
    plan.push_back(plan_row_t'{pointer_event(OP_MUP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    foreach (plan[i]) send_event(plan[i].ev, plan[i].typed, plan[i].want);

    drain_results();
    write_tap_radius('0);
    send_random(250);
    drain_results();
    write_tap_radius('1);
    send_random(250);

    drain_results();
    src_idle_pct = 51;
    sink_idle_pct = 25;
    write_tap_radius(CFG_W'($urandom_range(4, 200)));
    send_random(400);

    drain_results();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    write_tap_radius(TAP_RADIUS_RESET);
    send_random(400);
    flood(OP_WHEEL, 8388607, -8388608, 260);
    flood(OP_WHEEL, -8388608, 8388607, 260);
    send_random(20);

    drain_results();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ptrk_pkg.sv
rtl/ptrk_in_stage.sv
rtl/ptrk_engine.sv
rtl/ptrk_out_stage.sv
rtl/touch_mouse_pointer_tracker_core.sv
rtl/ptrk_checker.sv
verif/touch_mouse_pointer_tracker_core_test.sv
